>>> rtl/lome_pkg.sv
// Package for the limit order matching engine: widths, command and status codes,
// the queued command record and the slot record. No dependencies.
`timescale 1ns / 1ps
package lome_pkg;
  localparam int OrderSlots = 64;
  localparam int SlotW = $clog2(OrderSlots);
  // Nodes of a binary compare tree over all slots; leaves sit after the inner nodes.
  localparam int TreeNodes = 2 * OrderSlots - 1;
  localparam int IdW = 31;
  localparam int PriceW = 24;
  localparam int VolW = 24;
  localparam int ClientW = 8;
  localparam int ArrW = 32;

  localparam logic [1:0] CMD_PLACE = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  localparam logic [2:0] ST_SUCCESS = 3'd0;
  localparam logic [2:0] ST_PARTIAL = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_FULL = 3'd6;

  // Request after classification by the front end.
  typedef struct packed {
    logic [1:0] command;
    logic bad_values;
    logic [IdW-1:0] oid;
    logic side;
    logic [PriceW-1:0] price;
    logic [VolW-1:0] volume;
    logic [ClientW-1:0] client;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] oid;
    logic side;
    logic [PriceW-1:0] price;
    logic [VolW-1:0] remaining;
    logic [ClientW-1:0] client;
    logic [ArrW-1:0] arrival;
  } slot_t;
endpackage

>>> rtl/lome_front.sv
// Front end: takes in requests, checks price and volume, and holds them
// in a two-entry queue for the matching core. Depends on lome_pkg.
`timescale 1ns / 1ps
module lome_front import lome_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [IdW-1:0] in_oid,
  input  logic in_side,
  input  logic [PriceW-1:0] in_price,
  input  logic [VolW-1:0] in_volume,
  input  logic [ClientW-1:0] in_client,
  output logic q_valid,
  output req_t q_req,
  input  logic q_take
);
  req_t q_mem_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  req_t in_req;
  logic push;

  // Classify the incoming request.
  always_comb begin
    in_req.command = in_command;
    in_req.bad_values = (in_price == '0) || (in_volume == '0);
    in_req.oid = in_oid;
    in_req.side = in_side;
    in_req.price = in_price;
    in_req.volume = in_volume;
    in_req.client = in_client;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = q_mem_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_req;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_take) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("take from empty queue");
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_take) |=> cnt_r == 2'd2) else $error("queue lost entry");
`endif
endmodule

>>> rtl/lome_core.sv
// Matching core: holds the order book in slot registers, runs search, match,
// rest and best-price passes, and drives the result register. Depends on lome_pkg.
`timescale 1ns / 1ps
module lome_core import lome_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  req_t q_req,
  output logic q_take,
  output logic out_valid,
  input  logic out_stall,
  output logic out_trade_valid,
  output logic [IdW-1:0] out_aggressor_id,
  output logic [ClientW-1:0] out_aggressor_client,
  output logic [PriceW-1:0] out_trade_price,
  output logic [VolW-1:0] out_fill_qty,
  output logic out_aggressor_buys,
  output logic [ClientW-1:0] out_counterparty_client,
  output logic [2:0] out_status,
  output logic [PriceW-1:0] out_top_bid,
  output logic [PriceW-1:0] out_top_ask,
  output logic out_last
);
  typedef enum logic [2:0] {S_IDLE, S_FIND, S_MATCH, S_FILL, S_REST, S_DONE, S_EMIT}
    state_t;

  state_t state_r;
  slot_t slot_r [OrderSlots];
  logic [OrderSlots-1:0] valid_r;
  logic [ArrW-1:0] arr_cnt_r;
  req_t req_r;
  logic report_r;
  logic [VolW-1:0] rem_r;
  logic [2:0] status_r;
  logic pend_r;          // a fill waits in the holding register, not yet known to be final

  // Holding register for the newest fill of a place.
  logic [PriceW-1:0] ppr_r;
  logic [VolW-1:0] pvol_r;
  logic [ClientW-1:0] pcc_r;

  // Match search results, registered.
  logic found_r;
  logic [SlotW-1:0] hit_r;

  // Output register.
  logic ov_r, otv_r, obuy_r, olast_r;
  logic [IdW-1:0] oid_r;
  logic [ClientW-1:0] ocl_r, occ_r;
  logic [PriceW-1:0] opr_r, obid_r, oask_r;
  logic [VolW-1:0] ovol_r;
  logic [2:0] ost_r;

  // Id lookup over all slots.
  logic id_hit;
  logic [SlotW-1:0] id_slot;
  always_comb begin
    id_hit = 1'b0;
    id_slot = '0;
    for (int i = OrderSlots - 1; i >= 0; i--) begin
      if (valid_r[i] && slot_r[i].oid == req_r.oid) begin
        id_hit = 1'b1;
        id_slot = SlotW'(i);
      end
    end
  end

  // Lowest free slot.
  logic free_hit;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_hit = 1'b0;
    free_slot = '0;
    for (int i = OrderSlots - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_hit = 1'b1;
        free_slot = SlotW'(i);
      end
    end
  end

  // Best crossing order by price, then age, as a compare tree; a tie keeps the
  // left branch, which holds the lower slots.
  logic nh [TreeNodes];
  logic [SlotW-1:0] ni [TreeNodes];
  logic [PriceW-1:0] np [TreeNodes];
  logic [ArrW-1:0] na [TreeNodes];
  logic best_hit;
  logic [SlotW-1:0] best_slot;
  always_comb begin
    for (int i = 0; i < OrderSlots; i++) begin
      nh[OrderSlots - 1 + i] = valid_r[i] && (slot_r[i].side != req_r.side) &&
        (req_r.side ? (slot_r[i].price >= req_r.price)
                    : (slot_r[i].price <= req_r.price));
      ni[OrderSlots - 1 + i] = SlotW'(i);
      np[OrderSlots - 1 + i] = slot_r[i].price;
      na[OrderSlots - 1 + i] = arr_cnt_r - slot_r[i].arrival;
    end
    for (int n = OrderSlots - 2; n >= 0; n--) begin
      if (nh[2*n+2] && (!nh[2*n+1] ||
          ((np[2*n+2] != np[2*n+1]) ?
             (req_r.side ? (np[2*n+2] > np[2*n+1]) : (np[2*n+2] < np[2*n+1])) :
             (na[2*n+2] > na[2*n+1])))) begin
        nh[n] = 1'b1;
        ni[n] = ni[2*n+2];
        np[n] = np[2*n+2];
        na[n] = na[2*n+2];
      end else begin
        nh[n] = nh[2*n+1];
        ni[n] = ni[2*n+1];
        np[n] = np[2*n+1];
        na[n] = na[2*n+1];
      end
    end
    best_hit = nh[0];
    best_slot = ni[0];
  end

  // Best bid and ask over the book, also as compare trees.
  logic [PriceW-1:0] bn [TreeNodes];
  logic ah [TreeNodes];
  logic [PriceW-1:0] an [TreeNodes];
  logic [PriceW-1:0] bid, ask;
  always_comb begin
    for (int i = 0; i < OrderSlots; i++) begin
      bn[OrderSlots - 1 + i] = (valid_r[i] && !slot_r[i].side) ? slot_r[i].price : '0;
      ah[OrderSlots - 1 + i] = valid_r[i] && slot_r[i].side;
      an[OrderSlots - 1 + i] = slot_r[i].price;
    end
    for (int n = OrderSlots - 2; n >= 0; n--) begin
      bn[n] = (bn[2*n+2] > bn[2*n+1]) ? bn[2*n+2] : bn[2*n+1];
      if (ah[2*n+2] && (!ah[2*n+1] || an[2*n+2] < an[2*n+1])) begin
        ah[n] = 1'b1;
        an[n] = an[2*n+2];
      end else begin
        ah[n] = ah[2*n+1];
        an[n] = an[2*n+1];
      end
    end
    bid = bn[0];
    ask = ah[0] ? an[0] : '0;
  end

  logic [VolW-1:0] fill;
  assign fill = (rem_r < slot_r[hit_r].remaining) ? rem_r : slot_r[hit_r].remaining;
  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign q_take = (state_r == S_IDLE) && q_valid;

  // A later fill of a place first sends the held one out, so it needs the result register.
  logic fill_go;
  assign fill_go = !report_r || !pend_r || out_free;
  logic ov_set;
  assign ov_set = ((state_r == S_FILL) && fill_go && report_r && pend_r) ||
                  ((state_r == S_DONE) && out_free);

  // Sequencer, book and result register contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      arr_cnt_r <= '0;
      pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            rem_r <= q_req.volume;
            report_r <= (q_req.command == CMD_PLACE);
            pend_r <= 1'b0;
            state_r <= S_FIND;
          end
        end
        S_FIND: begin
          state_r <= S_DONE;
          case (req_r.command)
            CMD_PLACE: begin
              if (req_r.bad_values) status_r <= ST_INVALID;
              else if (id_hit) status_r <= ST_DUPLICATE;
              else state_r <= S_MATCH;
            end
            CMD_CANCEL: begin
              if (!id_hit) status_r <= ST_NOTFOUND;
              else begin
                valid_r[id_slot] <= 1'b0;
                status_r <= ST_SUCCESS;
              end
            end
            CMD_MODIFY: begin
              if (!id_hit) status_r <= ST_NOTFOUND;
              else begin
                valid_r[id_slot] <= 1'b0;
                req_r.side <= slot_r[id_slot].side;
                req_r.client <= slot_r[id_slot].client;
                if (req_r.bad_values) status_r <= ST_INVALID;
                else state_r <= S_MATCH;
              end
            end
            default: status_r <= ST_INVALID;
          endcase
        end
        S_MATCH: begin
          found_r <= best_hit;
          hit_r <= best_slot;
          state_r <= best_hit ? S_FILL : S_REST;
        end
        S_FILL: begin
          if (fill_go) begin
            slot_r[hit_r].remaining <= slot_r[hit_r].remaining - fill;
            if (slot_r[hit_r].remaining == fill) valid_r[hit_r] <= 1'b0;
            rem_r <= rem_r - fill;
            if (report_r) begin
              // The held fill is not the last one, so it leaves now.
              if (pend_r) begin
                olast_r <= 1'b0;
                ost_r <= '0;
                obid_r <= '0;
                oask_r <= '0;
                otv_r <= 1'b1;
                oid_r <= req_r.oid;
                ocl_r <= req_r.client;
                opr_r <= ppr_r;
                ovol_r <= pvol_r;
                obuy_r <= !req_r.side;
                occ_r <= pcc_r;
              end
              ppr_r <= slot_r[hit_r].price;
              pvol_r <= fill;
              pcc_r <= slot_r[hit_r].client;
              pend_r <= 1'b1;
            end
            state_r <= (rem_r == fill) ? S_REST : S_MATCH;
          end
        end
        S_REST: begin
          state_r <= S_DONE;
          if (rem_r == '0) status_r <= ST_COMPLETE;
          else if (!free_hit) status_r <= ST_FULL;
          else begin
            valid_r[free_slot] <= 1'b1;
            slot_r[free_slot].oid <= req_r.oid;
            slot_r[free_slot].side <= req_r.side;
            slot_r[free_slot].price <= req_r.price;
            slot_r[free_slot].remaining <= rem_r;
            slot_r[free_slot].client <= req_r.client;
            slot_r[free_slot].arrival <= arr_cnt_r;
            arr_cnt_r <= arr_cnt_r + 1'b1;
            status_r <= (rem_r != req_r.volume) ? ST_PARTIAL : ST_SUCCESS;
          end
        end
        S_DONE: begin
          // Held fill becomes the final result, or a blank final result is built.
          if (out_free) begin
            if (pend_r) begin
              otv_r <= 1'b1;
              oid_r <= req_r.oid;
              ocl_r <= req_r.client;
              opr_r <= ppr_r;
              ovol_r <= pvol_r;
              obuy_r <= !req_r.side;
              occ_r <= pcc_r;
            end else begin
              otv_r <= 1'b0;
              oid_r <= '0;
              ocl_r <= '0;
              opr_r <= '0;
              ovol_r <= '0;
              obuy_r <= 1'b0;
              occ_r <= '0;
            end
            olast_r <= 1'b1;
            ost_r <= status_r;
            obid_r <= bid;
            oask_r <= ask;
            pend_r <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ov_r || !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result valid: set when a result is loaded, cleared once it has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ov_set) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  assign out_valid = ov_r;
  assign out_trade_valid = otv_r;
  assign out_aggressor_id = oid_r;
  assign out_aggressor_client = ocl_r;
  assign out_trade_price = opr_r;
  assign out_fill_qty = ovol_r;
  assign out_aggressor_buys = obuy_r;
  assign out_counterparty_client = occ_r;
  assign out_status = ost_r;
  assign out_top_bid = obid_r;
  assign out_top_ask = oask_r;
  assign out_last = olast_r;

`ifndef SYNTH
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r) else $error("result dropped while stalled");
  a_fill_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (found_r && valid_r[hit_r])) else $error("fill of empty slot");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> state_r == S_FIND) else $error("request taken outside idle");
`endif
endmodule

>>> rtl/limit_order_matching_engine_top.sv
// Limit order matching engine, top level: joins the front-end queue and the
// matching core. Depends on lome_pkg, lome_front and lome_core.
`timescale 1ns / 1ps
// Requests are queued two deep at the front and carried out one at a time by the
// core. A cancel or a rejected request passes the find, done and emit states. A
// place or a modify passes find, then match and fill in turn while an order crosses,
// then rest, done and emit; each pass is one price-time compare tree over all slots
// followed by the fill update. A stalled result holds the core: the second and
// later fills of a place wait until the held fill can leave. Each request ends
// with one result marked last.
module limit_order_matching_engine_top import lome_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [IdW-1:0] in_oid,
  input  logic in_side,
  input  logic [PriceW-1:0] in_price,
  input  logic [VolW-1:0] in_volume,
  input  logic [ClientW-1:0] in_client,
  output logic out_valid,
  input  logic out_stall,
  output logic out_trade_valid,
  output logic [IdW-1:0] out_aggressor_id,
  output logic [ClientW-1:0] out_aggressor_client,
  output logic [PriceW-1:0] out_trade_price,
  output logic [VolW-1:0] out_fill_qty,
  output logic out_aggressor_buys,
  output logic [ClientW-1:0] out_counterparty_client,
  output logic [2:0] out_status,
  output logic [PriceW-1:0] out_top_bid,
  output logic [PriceW-1:0] out_top_ask,
  output logic out_last
);
  logic q_valid, q_take;
  req_t q_req;

  // Request intake and queue.
  lome_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_oid, .in_side,
    .in_price, .in_volume, .in_client, .q_valid, .q_req, .q_take
  );

  // Order book and matching.
  lome_core u_core (
    .clk, .rst_n, .q_valid, .q_req, .q_take, .out_valid, .out_stall,
    .out_trade_valid, .out_aggressor_id, .out_aggressor_client, .out_trade_price,
    .out_fill_qty, .out_aggressor_buys, .out_counterparty_client, .out_status,
    .out_top_bid, .out_top_ask, .out_last
  );
endmodule

>>> tb/sv/tb_limit_order_matching_engine_top.sv
// Testbench for the limit order matching engine top level: directed and random
// requests checked by a price-time order book predictor. Depends on lome_pkg and the top level.
`timescale 1ns / 1ps
module tb_limit_order_matching_engine_top;
  import lome_pkg::*;

  // Command 3 is not defined by the package; it is treated as invalid.
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam int CycleLimit = 10000000;

  typedef struct packed {
    logic trade_valid;
    logic [IdW-1:0] aggressor_id;
    logic [ClientW-1:0] aggressor_client;
    logic [PriceW-1:0] trade_price;
    logic [VolW-1:0] fill_qty;
    logic aggressor_buys;
    logic [ClientW-1:0] counterparty_client;
    logic [2:0] status;
    logic [PriceW-1:0] top_bid;
    logic [PriceW-1:0] top_ask;
    logic last;
  } fill_report_t;

  // Order book model plus the queue of reports still owed by the block.
  class book_scoreboard;
    bit live[OrderSlots];
    bit [IdW-1:0] oid[OrderSlots];
    bit sd[OrderSlots];
    bit [PriceW-1:0] px[OrderSlots];
    bit [VolW-1:0] rem[OrderSlots];
    bit [ClientW-1:0] cl[OrderSlots];
    bit [ArrW-1:0] arr[OrderSlots];
    bit [ArrW-1:0] arrivals;
    fill_report_t pending_reports[$];
    int errors;
    int fills_seen;
    int fulls_seen;

    function int find_id(bit [IdW-1:0] id);
      for (int i = 0; i < OrderSlots; i++)
        if (live[i] && oid[i] == id) return i;
      return -1;
    endfunction

    function int resting_count();
      int n;
      n = 0;
      foreach (live[i]) n += live[i];
      return n;
    endfunction

    // Match then rest; fills are queued only when report is set.
    function logic [2:0] match_order(bit [IdW-1:0] id, bit s, bit [PriceW-1:0] p,
                                     bit [VolW-1:0] v, bit [ClientW-1:0] c, bit report,
                                     ref fill_report_t fills[$]);
      bit [VolW-1:0] left;
      bit [VolW-1:0] qty;
      int best;
      int f;
      bit crosses;
      fill_report_t r;
      left = v;
      if (v == 0 || p == 0) return ST_INVALID;
      if (find_id(id) >= 0) return ST_DUPLICATE;
      while (left > 0) begin
        best = -1;
        for (int i = 0; i < OrderSlots; i++) begin
          if (!live[i] || sd[i] == s) continue;
          crosses = (s == 1'b0) ? (px[i] <= p) : (px[i] >= p);
          if (!crosses) continue;
          if (best < 0) best = i;
          else if (px[i] != px[best]) begin
            if ((s == 1'b0) ? (px[i] < px[best]) : (px[i] > px[best])) best = i;
          end else if (ArrW'(arrivals - arr[i]) > ArrW'(arrivals - arr[best])) best = i;
        end
        if (best < 0) break;
        qty = (left < rem[best]) ? left : rem[best];
        rem[best] -= qty;
        left -= qty;
        if (report && fills.size() < OrderSlots) begin
          r = '{default: '0};
          r.trade_valid = 1'b1;
          r.aggressor_id = id;
          r.aggressor_client = c;
          r.trade_price = px[best];
          r.fill_qty = qty;
          r.aggressor_buys = (s == 1'b0);
          r.counterparty_client = cl[best];
          fills.insert(fills.size(), r);
        end
        if (rem[best] == 0) live[best] = 0;
      end
      if (left == 0) return ST_COMPLETE;
      f = -1;
      for (int i = OrderSlots - 1; i >= 0; i--) if (!live[i]) f = i;
      if (f < 0) return ST_FULL;
      live[f] = 1; oid[f] = id; sd[f] = s; px[f] = p; rem[f] = left; cl[f] = c;
      arr[f] = arrivals;
      arrivals++;
      return (left < v) ? ST_PARTIAL : ST_SUCCESS;
    endfunction

    // Notes an accepted request and queues the reports it must produce.
    function void note_request(logic [1:0] cmd, logic [IdW-1:0] id, logic s,
                               logic [PriceW-1:0] p, logic [VolW-1:0] v,
                               logic [ClientW-1:0] c);
      fill_report_t fills[$];
      fill_report_t r;
      logic [2:0] st;
      int k;
      bit [PriceW-1:0] bid, ask;
      bit have_ask;
      if (cmd == CMD_PLACE) st = match_order(id, s, p, v, c, 1, fills);
      else if (cmd == CMD_CANCEL || cmd == CMD_MODIFY) begin
        k = find_id(id);
        if (k < 0) st = ST_NOTFOUND;
        else if (cmd == CMD_CANCEL) begin
          live[k] = 0;
          st = ST_SUCCESS;
        end else begin
          live[k] = 0;
          st = match_order(id, sd[k], p, v, cl[k], 0, fills);
        end
      end else st = ST_INVALID;
      if (st == ST_FULL) fulls_seen++;
      if (fills.size() == 0) begin
        r = '{default: '0};
        fills.insert(0, r);
      end
      bid = 0; ask = 0; have_ask = 0;
      for (int i = 0; i < OrderSlots; i++) begin
        if (!live[i]) continue;
        if (sd[i] == 1'b0) begin
          if (px[i] > bid) bid = px[i];
        end else if (!have_ask || px[i] < ask) begin
          ask = px[i];
          have_ask = 1;
        end
      end
      r = fills[$];
      r.status = st; r.top_bid = bid; r.top_ask = ask; r.last = 1'b1;
      fills[$] = r;
      foreach (fills[i]) pending_reports.insert(pending_reports.size(), fills[i]);
    endfunction

    // Compares one accepted report with the oldest one owed.
    function void check_report(fill_report_t got);
      fill_report_t exp;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report: status %0d", $time, got.status);
        errors++;
        return;
      end
      exp = pending_reports[0];
      pending_reports.delete(0);
      if (got.trade_valid) fills_seen++;
      if (got !== exp) begin
        $display("%0t: mismatch expected tv=%0d id=%0h ac=%0d px=%0d vol=%0d buy=%0d",
                 $time, exp.trade_valid, exp.aggressor_id, exp.aggressor_client,
                 exp.trade_price, exp.fill_qty, exp.aggressor_buys);
        $display("    cc=%0d st=%0d bb=%0d ba=%0d last=%0d",
                 exp.counterparty_client, exp.status, exp.top_bid, exp.top_ask, exp.last);
        $display("%0t: mismatch actual   tv=%0d id=%0h ac=%0d px=%0d vol=%0d buy=%0d",
                 $time, got.trade_valid, got.aggressor_id, got.aggressor_client,
                 got.trade_price, got.fill_qty, got.aggressor_buys);
        $display("    cc=%0d st=%0d bb=%0d ba=%0d last=%0d",
                 got.counterparty_client, got.status, got.top_bid, got.top_ask, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_command;
  logic [IdW-1:0] in_oid;
  logic in_side;
  logic [PriceW-1:0] in_price;
  logic [VolW-1:0] in_volume;
  logic [ClientW-1:0] in_client;
  logic out_valid;
  logic out_stall;
  logic out_trade_valid;
  logic [IdW-1:0] out_aggressor_id;
  logic [ClientW-1:0] out_aggressor_client;
  logic [PriceW-1:0] out_trade_price;
  logic [VolW-1:0] out_fill_qty;
  logic out_aggressor_buys;
  logic [ClientW-1:0] out_counterparty_client;
  logic [2:0] out_status;
  logic [PriceW-1:0] out_top_bid;
  logic [PriceW-1:0] out_top_ask;
  logic out_last;
  fill_report_t seen;

  book_scoreboard book;
  int cycles;
  bit long_hold;
  bit [IdW-1:0] used_ids[$];

  limit_order_matching_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_oid(in_oid), .in_side(in_side), .in_price(in_price),
    .in_volume(in_volume), .in_client(in_client),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_trade_valid(out_trade_valid), .out_aggressor_id(out_aggressor_id),
    .out_aggressor_client(out_aggressor_client), .out_trade_price(out_trade_price),
    .out_fill_qty(out_fill_qty), .out_aggressor_buys(out_aggressor_buys),
    .out_counterparty_client(out_counterparty_client), .out_status(out_status),
    .out_top_bid(out_top_bid), .out_top_ask(out_top_ask), .out_last(out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("limit_order_matching_engine_top test failed");
      $finish;
    end
  end

  // Result side: accepted reports are checked at the clock edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{trade_valid: out_trade_valid, aggressor_id: out_aggressor_id,
               aggressor_client: out_aggressor_client, trade_price: out_trade_price,
               fill_qty: out_fill_qty, aggressor_buys: out_aggressor_buys,
               counterparty_client: out_counterparty_client, status: out_status,
               top_bid: out_top_bid, top_ask: out_top_ask, last: out_last};
      book.check_report(seen);
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        long_hold = 0;
      end
      mode = $urandom_range(0, 3);
      hold = $urandom_range(1, 30);
      for (int i = 0; i < hold && !long_hold; i++) begin
        out_stall <= (mode == 0) ? 1'b0 : (mode == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
        @(posedge clk);
      end
    end
  end

  // Offers one request and waits until it is accepted.
  task automatic send_request(logic [1:0] cmd, logic [IdW-1:0] id, logic s,
                              logic [PriceW-1:0] p, logic [VolW-1:0] v,
                              logic [ClientW-1:0] c);
    in_valid <= 1'b1;
    in_command <= cmd; in_oid <= id; in_side <= s;
    in_price <= p; in_volume <= v; in_client <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(cmd, id, s, p, v, c);
    if (cmd == CMD_PLACE) used_ids.insert(used_ids.size(), id);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_book_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_reports.size() != 0) @(posedge clk);
  endtask

  // Random request, mostly well formed around a narrow price band.
  task automatic send_random_request();
    logic [1:0] cmd;
    logic [IdW-1:0] id;
    logic [PriceW-1:0] p;
    logic [VolW-1:0] v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) cmd = CMD_PLACE;
    else if (pick < 80) cmd = CMD_CANCEL;
    else if (pick < 95) cmd = CMD_MODIFY;
    else cmd = CMD_UNDEFINED;
    if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
      id = used_ids[$urandom_range(0, used_ids.size() - 1)];
    else id = IdW'($urandom);
    p = ($urandom_range(0, 19) == 0) ? PriceW'($urandom)
                                     : PriceW'(1000 + $urandom_range(0, 16) - 8);
    v = ($urandom_range(0, 9) == 0) ? VolW'($urandom) : VolW'($urandom_range(1, 60));
    if ($urandom_range(0, 39) == 0) p = 0;
    if ($urandom_range(0, 39) == 0) v = 0;
    send_request(cmd, id, 1'($urandom_range(0, 1)), p, v,
                 ClientW'($urandom_range(0, 255)));
  endtask

  initial begin
    int sent;
    int burst;
    book = new();
    cycles = 0;
    long_hold = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_PLACE; in_oid <= '0; in_side <= 1'b0;
    in_price <= '0; in_volume <= '0; in_client <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: invalid values, duplicates, unknown ids, field extremes, sweeps.
    send_request(CMD_PLACE, 31'd1, 1'b0, '0, 24'd5, 8'd1);
    send_request(CMD_PLACE, 31'd1, 1'b0, 24'd10, '0, 8'd1);
    send_request(CMD_CANCEL, 31'd77, 1'b0, 24'd10, 24'd5, 8'd0);
    send_request(CMD_MODIFY, 31'd78, 1'b1, 24'd10, 24'd5, 8'd0);
    send_request(CMD_UNDEFINED, '1, 1'b1, '1, '1, '1);
    send_request(CMD_PLACE, 31'h7fffffff, 1'b1, 24'hffffff, 24'hffffff, 8'hff);
    send_request(CMD_PLACE, 31'h7fffffff, 1'b1, 24'd20, 24'd3, 8'd2);
    send_request(CMD_PLACE, 31'd10, 1'b1, 24'd100, 24'd5, 8'd3);
    send_request(CMD_PLACE, 31'd11, 1'b1, 24'd100, 24'd7, 8'd4);
    send_request(CMD_PLACE, 31'd12, 1'b1, 24'd99, 24'd4, 8'd5);
    send_request(CMD_PLACE, 31'd20, 1'b0, 24'd100, 24'd12, 8'd6);
    send_request(CMD_PLACE, 31'd21, 1'b0, 24'd98, 24'd9, 8'd7);
    send_request(CMD_PLACE, 31'd22, 1'b1, 24'd1, 24'hffffff, 8'd8);
    send_request(CMD_MODIFY, 31'd22, 1'b0, 24'd500, 24'd2, 8'd0);
    send_request(CMD_MODIFY, 31'd22, 1'b0, '0, 24'd2, 8'd0);
    send_request(CMD_CANCEL, 31'h7fffffff, 1'b0, '0, '0, 8'd0);
    send_request(CMD_PLACE, 31'd30, 1'b0, 24'd1, 24'd1, 8'd0);
    send_request(CMD_MODIFY, 31'd30, 1'b1, 24'd2, 24'd1, 8'd9);
    drain_book_reports();

    // Fill the book with non-crossing buys, then a full reject and a sweep.
    for (int i = 0; i < OrderSlots; i++)
      send_request(CMD_PLACE, 31'(1000 + i), 1'b0, 24'(10 + i % 5), 24'd2, 8'(i));
    send_request(CMD_PLACE, 31'd2000, 1'b0, 24'd10, 24'd2, 8'd1);
    send_request(CMD_PLACE, 31'd2001, 1'b1, 24'd10, 24'd200, 8'd2);
    drain_book_reports();

    // Long receiver hold-off while requests keep flowing.
    long_hold = 1;
    sent = 0;
    while (sent < 360) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        send_random_request();
        sent++;
      end
      if (sent > 200 && sent < 215) drain_book_reports();
      else if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 20));
      // Occasionally clear the book so fill-ups recur.
      if (book.resting_count() > 56 && $urandom_range(0, 3) == 0)
        send_request(CMD_PLACE, IdW'($urandom), 1'($urandom_range(0, 1)), 24'd1000,
                     24'd50, 8'd0);
    end
    drain_book_reports();
    idle_cycles(200);
    $display("Ran %0d random requests after the directed set: %0d fills, %0d full rejects.",
             sent, book.fills_seen, book.fulls_seen);
    if (book.errors == 0 && book.pending_reports.size() == 0)
      $display("limit_order_matching_engine_top test passed");
    else
      $display("limit_order_matching_engine_top test failed");
    $finish;
  end
endmodule
